// File: design/mcot_pkg.sv
// Shared types and constants for the multi-channel one-shot timer.
package mcot_pkg;

	localparam int TIMER_COUNT_DEF = 16;
	localparam int TIME_WIDTH_DEF  = 32;

	localparam int CMD_W     = 2;
	localparam int ID_IN_W   = 5;
	localparam int TIMEOUT_W = 31;
	localparam int FID_W     = 4;
	localparam int CFG_W     = 5;

	localparam logic [CFG_W-1:0] TIMERS_IN_USE_RST = CFG_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_SET    = 2'd1,
		CMD_CANCEL = 2'd2,
		CMD_RESET  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic             status;
		logic             fired;
		logic [FID_W-1:0] fired_id;
		logic             last;
	} res_t;

endpackage

// File: design/mcot_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module mcot_ram #(
	parameter int W = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/mcot_ctrl.sv
// Command sequencer and pipelined walk over the order queue and expiry memories.
module mcot_ctrl #(
	parameter int TIMER_COUNT = mcot_pkg::TIMER_COUNT_DEF,
	parameter int TIME_WIDTH = mcot_pkg::TIME_WIDTH_DEF,
	localparam int IDW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1,
	localparam int QLW = $clog2(TIMER_COUNT + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mcot_pkg::CMD_W-1:0]     command,
	input  logic [mcot_pkg::ID_IN_W-1:0]   timer_id,
	input  logic [mcot_pkg::TIMEOUT_W-1:0] timeout,
	input  logic [mcot_pkg::CFG_W-1:0]     timers_in_use,
	output logic                           res_push,
	output mcot_pkg::res_t                 res,
	input  logic                           res_free,
	output logic                           q_we,
	output logic [IDW-1:0]                 q_waddr,
	output logic [IDW-1:0]                 q_wdata,
	output logic                           q_re,
	output logic [IDW-1:0]                 q_raddr,
	input  logic [IDW-1:0]                 q_rdata,
	output logic                           exp_we,
	output logic [IDW-1:0]                 exp_waddr,
	output logic [TIME_WIDTH-1:0]          exp_wdata,
	output logic                           exp_re,
	output logic [IDW-1:0]                 exp_raddr,
	input  logic [TIME_WIDTH-1:0]          exp_rdata
);

	import mcot_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FIN} state_t;
	typedef enum logic [1:0] {MODE_NONE, MODE_TICK, MODE_CANCEL, MODE_SET} mode_t;

	state_t                  state_q;
	mode_t                   mode_q;
	logic                    reset_q;
	logic                    rej_q;
	logic                    ins_q;
	logic                    pend_v_q;
	logic                    valid_s1;
	logic                    valid_s2;
	logic [QLW-1:0]          rd_ptr_q;
	logic [QLW-1:0]          w_q;
	logic [QLW-1:0]          len_q;
	logic [TIME_WIDTH-1:0]   time_q;
	logic [TIMER_COUNT-1:0]  active_q;

	logic [IDW-1:0]          id_q;
	logic [IDW-1:0]          tid_s2;
	logic [IDW-1:0]          carry_q;
	logic [IDW-1:0]          pend_id_q;
	logic [TIME_WIDTH-1:0]   offs_q;
	logic [TIME_WIDTH-1:0]   exp_new_q;

	logic                    accept;
	logic                    walking;
	logic                    issue;
	logic                    walk_done;
	logic                    ev;
	logic                    fire;
	logic                    fin;
	logic                    to_set;
	logic                    later;
	logic                    id_ok;
	logic                    id_act;
	logic                    full;
	logic [IDW-1:0]          idn;
	logic [TIME_WIDTH-1:0]   dlt;
	logic [TIME_WIDTH-1:0]   tmo;

	always_comb begin
		accept  = (state_q == ST_IDLE) && in_valid;
		in_stall = (state_q != ST_IDLE);
		idn     = IDW'(timer_id);
		id_ok   = (32'(timer_id) < 32'(TIMER_COUNT)) && (timer_id < timers_in_use);
		id_act  = id_ok && active_q[idn];
		full    = (len_q == QLW'(TIMER_COUNT));
		tmo     = TIME_WIDTH'(timeout);

		walking   = (state_q == ST_WALK) && res_free;
		issue     = (rd_ptr_q < len_q);
		walk_done = !issue && !valid_s1 && !valid_s2;

		q_re      = walking && issue;
		q_raddr   = rd_ptr_q[IDW-1:0];
		exp_re    = walking && valid_s1;
		exp_raddr = q_rdata;

		dlt   = exp_rdata - time_q;
		later = (dlt > offs_q);
		ev    = walking && valid_s2;
		fin   = (state_q == ST_FIN) && res_free;
		to_set = fin && (mode_q == MODE_CANCEL) && reset_q;

		q_we      = 1'b0;
		q_waddr   = w_q[IDW-1:0];
		q_wdata   = tid_s2;
		exp_we    = 1'b0;
		exp_waddr = id_q;
		exp_wdata = exp_new_q;
		fire      = 1'b0;
		res_push  = 1'b0;
		res       = '0;

		if (ev) begin
			case (mode_q)
				MODE_TICK: begin
					if (dlt == '0 || dlt[TIME_WIDTH-1]) begin
						fire = 1'b1;
						if (pend_v_q) begin
							res_push     = 1'b1;
							res.fired    = 1'b1;
							res.fired_id = FID_W'(pend_id_q);
						end
					end else begin
						q_we = 1'b1;
					end
				end
				MODE_CANCEL: begin
					q_we = (tid_s2 != id_q);
				end
				MODE_SET: begin
					q_we = 1'b1;
					if (ins_q) begin
						q_wdata = carry_q;
					end else if (later) begin
						q_wdata = id_q;
					end
				end
				default: ;
			endcase
		end

		if (fin) begin
			if (mode_q == MODE_SET) begin
				q_we    = 1'b1;
				q_wdata = ins_q ? carry_q : id_q;
				exp_we  = 1'b1;
			end
			if (!to_set) begin
				res_push   = 1'b1;
				res.status = rej_q;
				res.last   = 1'b1;
				if (mode_q == MODE_TICK && pend_v_q) begin
					res.fired    = 1'b1;
					res.fired_id = FID_W'(pend_id_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= MODE_NONE;
			reset_q  <= 1'b0;
			rej_q    <= 1'b0;
			ins_q    <= 1'b0;
			pend_v_q <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			rd_ptr_q <= '0;
			w_q      <= '0;
			len_q    <= '0;
			time_q   <= '0;
			active_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_ptr_q <= '0;
						w_q      <= '0;
						ins_q    <= 1'b0;
						pend_v_q <= 1'b0;
						valid_s1 <= 1'b0;
						valid_s2 <= 1'b0;
						reset_q  <= 1'b0;
						rej_q    <= 1'b0;
						state_q  <= ST_WALK;
						case (command)
							CMD_TICK: begin
								time_q <= time_q + 1'b1;
								mode_q <= MODE_TICK;
							end
							CMD_SET: begin
								if (id_ok && !id_act && !full) begin
									mode_q <= MODE_SET;
								end else begin
									mode_q  <= MODE_NONE;
									rej_q   <= 1'b1;
									state_q <= ST_FIN;
								end
							end
							CMD_CANCEL: begin
								if (id_act) begin
									mode_q        <= MODE_CANCEL;
									active_q[idn] <= 1'b0;
								end else begin
									mode_q  <= MODE_NONE;
									rej_q   <= 1'b1;
									state_q <= ST_FIN;
								end
							end
							CMD_RESET: begin
								if (id_act) begin
									mode_q        <= MODE_CANCEL;
									reset_q       <= 1'b1;
									active_q[idn] <= 1'b0;
								end else if (id_ok && !full) begin
									mode_q <= MODE_SET;
								end else begin
									mode_q  <= MODE_NONE;
									state_q <= ST_FIN;
								end
							end
							default: begin
								mode_q  <= MODE_NONE;
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (res_free) begin
						rd_ptr_q <= rd_ptr_q + QLW'(issue);
						valid_s1 <= issue;
						valid_s2 <= valid_s1;
						if (ev && q_we) begin
							w_q <= w_q + 1'b1;
						end
						if (fire) begin
							active_q[tid_s2] <= 1'b0;
							pend_v_q         <= 1'b1;
						end
						if (ev && mode_q == MODE_SET && later) begin
							ins_q <= 1'b1;
						end
						if (walk_done) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (res_free) begin
						state_q <= ST_IDLE;
						case (mode_q)
							MODE_TICK: begin
								len_q    <= w_q;
								pend_v_q <= 1'b0;
							end
							MODE_CANCEL: begin
								len_q <= w_q;
								if (reset_q) begin
									mode_q   <= MODE_SET;
									reset_q  <= 1'b0;
									rd_ptr_q <= '0;
									w_q      <= '0;
									ins_q    <= 1'b0;
									state_q  <= ST_WALK;
								end
							end
							MODE_SET: begin
								len_q          <= len_q + 1'b1;
								active_q[id_q] <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q      <= idn;
			offs_q    <= tmo;
			exp_new_q <= time_q + tmo;
		end
		if (walking) begin
			tid_s2 <= q_rdata;
		end
		if (ev && mode_q == MODE_SET && (ins_q || later)) begin
			carry_q <= tid_s2;
		end
		if (fire) begin
			pend_id_q <= tid_s2;
		end
	end

endmodule

// File: design/multi_channel_oneshot_timer.sv
// Top level of the multi-channel one-shot timer: configuration, result register, memories.
// A transaction walks the order queue one entry per cycle, while the output is not stalled,
// through the queue and expiry memories; a rejected command skips the walk. Its last result
// is registered, and the next command is taken once the controller is back in idle.
// A reset of an active timer walks twice; output stalls hold the walk. One at a time.
// arst_n clears time, active marks, queue length and sets timers_in_use to 16; no clearing pass.
module multi_channel_oneshot_timer #(
	parameter int TIMER_COUNT = mcot_pkg::TIMER_COUNT_DEF,
	parameter int TIME_WIDTH = mcot_pkg::TIME_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mcot_pkg::CMD_W-1:0]     command,
	input  logic [mcot_pkg::ID_IN_W-1:0]   timer_id,
	input  logic [mcot_pkg::TIMEOUT_W-1:0] timeout,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           status,
	output logic                           fired,
	output logic [mcot_pkg::FID_W-1:0]     fired_id,
	output logic                           last,
	input  logic                           cfg_we,
	input  logic [mcot_pkg::CFG_W-1:0]     cfg_wdata
);

	import mcot_pkg::*;

	localparam int IDW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

	logic [CFG_W-1:0]      timers_in_use_q;
	logic                  out_valid_q;
	res_t                  out_q;
	logic                  res_free;
	logic                  res_push;
	res_t                  res;

	logic                  q_we;
	logic [IDW-1:0]        q_waddr;
	logic [IDW-1:0]        q_wdata;
	logic                  q_re;
	logic [IDW-1:0]        q_raddr;
	logic [IDW-1:0]        q_rdata;
	logic                  exp_we;
	logic [IDW-1:0]        exp_waddr;
	logic [TIME_WIDTH-1:0] exp_wdata;
	logic                  exp_re;
	logic [IDW-1:0]        exp_raddr;
	logic [TIME_WIDTH-1:0] exp_rdata;

	assign res_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign fired     = out_q.fired;
	assign fired_id  = out_q.fired_id;
	assign last      = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timers_in_use_q <= TIMERS_IN_USE_RST;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				timers_in_use_q <= cfg_wdata;
			end
			if (res_push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q <= res;
		end
	end

	mcot_ram #(
		.W     (IDW),
		.DEPTH (TIMER_COUNT)
	) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (q_re),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	mcot_ram #(
		.W     (TIME_WIDTH),
		.DEPTH (TIMER_COUNT)
	) u_expiry_ram (
		.clk   (clk),
		.we    (exp_we),
		.waddr (exp_waddr),
		.wdata (exp_wdata),
		.re    (exp_re),
		.raddr (exp_raddr),
		.rdata (exp_rdata)
	);

	mcot_ctrl #(
		.TIMER_COUNT (TIMER_COUNT),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.timer_id      (timer_id),
		.timeout       (timeout),
		.timers_in_use (timers_in_use_q),
		.res_push      (res_push),
		.res           (res),
		.res_free      (res_free),
		.q_we          (q_we),
		.q_waddr       (q_waddr),
		.q_wdata       (q_wdata),
		.q_re          (q_re),
		.q_raddr       (q_raddr),
		.q_rdata       (q_rdata),
		.exp_we        (exp_we),
		.exp_waddr     (exp_waddr),
		.exp_wdata     (exp_wdata),
		.exp_re        (exp_re),
		.exp_raddr     (exp_raddr),
		.exp_rdata     (exp_rdata)
	);

endmodule
